// ===== sv/sktc_pkg.sv =====
package sktc_pkg;

  localparam int KEY_W   = 32;
  localparam int RANK_W  = 4;
  localparam int STAT_W  = 3;
  localparam int ECNT_W  = 16;
  localparam int OCC_W   = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NEW     = 3'd0,
    ST_COUNTED = 3'd1,
    ST_FULL    = 3'd2,
    ST_READ    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    logic                     command;
    logic signed [KEY_W-1:0]  key;
    logic [RANK_W-1:0]        rank;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [KEY_W-1:0]  entry_key;
    logic [ECNT_W-1:0]        entry_count;
    logic [RANK_W-1:0]        position;
    logic [OCC_W-1:0]         occupancy;
  } rsp_t;

  // Per-cycle controls broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_en;
    logic count_en;
  } cell_ctl_t;

endpackage

// ===== sv/sorted_key_count_table_core.sv =====
// Sorted key counter: holds up to CAPACITY distinct signed keys in ascending
// order in a chain of cells, each key with a saturating occurrence count. An
// insert request either counts a key already held, places a new key at its
// sorted place (larger entries move up one cell), or is dropped when the table
// is full; a read request returns the entry at an ascending rank. Every cell
// compares the broadcast key in parallel and the chain shifts in the same
// cycle, so one request is taken per clock and its response appears in the
// output register on the next cycle. The next request is taken in the cycle
// that response is accepted; while the response is held back, no request is
// taken. After reset the table is empty and ready at once.
module sorted_key_count_table_core import sktc_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int TOT_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [TOT_W-1:0]        total;
  logic [TOT_W-1:0]        total_next;
  logic signed [KEY_W-1:0] cell_key   [CAPACITY];
  logic [COUNT_BITS-1:0]   cell_count [CAPACITY];
  logic [CAPACITY-1:0]     above;
  logic [CAPACITY-1:0]     eq;
  logic [CAPACITY-1:0]     slot_hot;
  logic [CAPACITY-1:0]     rank_hot;
  cell_ctl_t               ctl;
  logic                    accept;
  logic                    is_insert;
  logic                    match_any;
  logic                    full;
  logic                    rank_ok;
  logic [COUNT_BITS-1:0]   match_count;
  logic [COUNT_BITS-1:0]   bumped_count;
  logic [COUNT_BITS-1:0]   read_count;
  logic signed [KEY_W-1:0] read_key;
  logic [RANK_W-1:0]       match_pos;
  logic [RANK_W-1:0]       slot_pos;
  logic [31:0]             wide_count;
  logic [31:0]             wide_total;
  rsp_t                    rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_insert = (req.command == CMD_INSERT);
  assign match_any = |eq;
  assign full      = (32'(total) >= CAPACITY);
  assign rank_ok   = (32'(req.rank) < 32'(total));

  assign ctl.count_en = accept && is_insert;
  assign ctl.shift_en = accept && is_insert && !match_any && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] p_key;
    logic [COUNT_BITS-1:0]   p_count;
    logic                    p_above;

    if (i == 0) begin : g_head
      assign p_key   = req.key;
      assign p_count = CountMax;
      assign p_above = 1'b0;
    end else begin : g_body
      assign p_key   = cell_key[i-1];
      assign p_count = cell_count[i-1];
      assign p_above = above[i-1];
    end

    sktc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk        (clk),
      .valid      (32'(i) < 32'(total)),
      .probe      (req.key),
      .prev_key   (p_key),
      .prev_count (p_count),
      .prev_above (p_above),
      .ctl        (ctl),
      .key        (cell_key[i]),
      .count      (cell_count[i]),
      .above      (above[i]),
      .eq         (eq[i])
    );

    assign slot_hot[i] = above[i] && !p_above;
    assign rank_hot[i] = (32'(req.rank) == i);
  end

  // One-hot selections folded by OR over the chain.
  always_comb begin
    match_count = '0;
    match_pos   = '0;
    slot_pos    = '0;
    read_key    = '0;
    read_count  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) begin
        match_count = match_count | cell_count[i];
        match_pos   = match_pos | RANK_W'(i);
      end
      if (slot_hot[i]) begin
        slot_pos = slot_pos | RANK_W'(i);
      end
      if (rank_hot[i]) begin
        read_key   = read_key | cell_key[i];
        read_count = read_count | cell_count[i];
      end
    end
  end

  assign bumped_count = (match_count == CountMax) ? CountMax
                                                  : match_count + COUNT_BITS'(1);

  always_comb begin
    total_next = total;
    wide_count = '0;
    rsp_next   = '0;
    if (is_insert) begin
      if (match_any) begin
        rsp_next.status    = ST_COUNTED;
        rsp_next.entry_key = req.key;
        wide_count         = 32'(bumped_count);
        rsp_next.position  = match_pos;
      end else if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        rsp_next.status    = ST_NEW;
        rsp_next.entry_key = req.key;
        wide_count         = 32'd1;
        rsp_next.position  = slot_pos;
        total_next         = total + TOT_W'(1);
      end
    end else if (rank_ok) begin
      rsp_next.status    = ST_READ;
      rsp_next.entry_key = read_key;
      wide_count         = 32'(read_count);
      rsp_next.position  = req.rank;
    end else begin
      rsp_next.status   = ST_EMPTY;
      rsp_next.position = req.rank;
    end
    rsp_next.entry_count = wide_count[ECNT_W-1:0];
    wide_total           = 32'(total_next);
    rsp_next.occupancy   = wide_total[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        total     <= total_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= CAPACITY)
    else $error("occupancy above capacity");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.shift_en |=> total == $past(total) + TOT_W'(1))
    else $error("new key did not raise occupancy");

  a_slot_found: assert property (@(posedge clk) disable iff (rst)
    ctl.shift_en |-> $onehot(slot_hot))
    else $error("no unique insertion place");

  a_match_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq))
    else $error("key held in more than one cell");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NEW |-> rsp.entry_count == ECNT_W'(1))
    else $error("new entry without count of one");
`endif

endmodule

// ===== sv/sktc_cell.sv =====
module sktc_cell import sktc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    valid,
  input  logic signed [KEY_W-1:0] probe,
  input  logic signed [KEY_W-1:0] prev_key,
  input  logic [COUNT_BITS-1:0]   prev_count,
  input  logic                    prev_above,
  input  cell_ctl_t               ctl,
  output logic signed [KEY_W-1:0] key,
  output logic [COUNT_BITS-1:0]   count,
  output logic                    above,
  output logic                    eq
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // An empty cell counts as holding a key above every probe.
  assign above = !valid || (key > probe);
  assign eq    = valid && (key == probe);

  always_ff @(posedge clk) begin
    if (ctl.shift_en && above) begin
      if (prev_above) begin
        key   <= prev_key;
        count <= prev_count;
      end else begin
        key   <= probe;
        count <= COUNT_BITS'(1);
      end
    end else if (ctl.count_en && eq && count != CountMax) begin
      count <= count + COUNT_BITS'(1);
    end
  end

endmodule
